FILE: rtl/core/speech_chip_register_handshake_core_assert.svh
// assertion macros used by the speech register block checker
`ifndef SPEECH_CHIP_REGISTER_HANDSHAKE_CORE_ASSERT_SVH
`define SPEECH_CHIP_REGISTER_HANDSHAKE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCRH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scrh same-cycle check failed");

// next-cycle implication, checked outside reset
`define SCRH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scrh next-cycle check failed");

`endif

FILE: rtl/core/scrh_pkg.sv
// types, codes and the alternate phoneme table of the speech register block
package scrh_pkg;

  typedef enum logic [1:0] {
    CMD_REG_WR = 2'd0,
    CMD_REG_RD = 2'd1,
    CMD_ALT_WR = 2'd2,
    CMD_DONE   = 2'd3
  } cmd_t;

  localparam logic [2:0] ADDR_DURATION   = 3'd0;
  localparam logic [2:0] ADDR_INFLECTION = 3'd1;
  localparam logic [2:0] ADDR_RATE       = 3'd2;
  localparam logic [2:0] ADDR_CONTROL    = 3'd3;

  localparam logic [7:0] PCR_ALT_DONE = 8'hB0;
  localparam logic [7:0] PCR_HOLD     = 8'h0C;
  localparam int         CtrlBit      = 7;

  typedef struct packed {
    logic       request_pin;
    logic       play_start;
    logic [5:0] phoneme_code;
    logic       cpu_irq_set;
    logic       cpu_irq_clear;
    logic       flag_peripheral_set;
    logic       flag_alt_set;
    logic       flag_alt_clear;
  } result_t;

  localparam logic [5:0] ALT_MAP [64] = '{
    6'h02, 6'h0A, 6'h0B, 6'h00, 6'h28, 6'h08, 6'h08, 6'h2F,
    6'h0E, 6'h07, 6'h07, 6'h07, 6'h37, 6'h38, 6'h24, 6'h33,
    6'h32, 6'h32, 6'h2F, 6'h10, 6'h39, 6'h0F, 6'h13, 6'h13,
    6'h20, 6'h29, 6'h25, 6'h2C, 6'h26, 6'h34, 6'h25, 6'h30,
    6'h08, 6'h09, 6'h03, 6'h1B, 6'h0E, 6'h27, 6'h11, 6'h07,
    6'h16, 6'h05, 6'h28, 6'h1D, 6'h01, 6'h23, 6'h0C, 6'h0D,
    6'h10, 6'h1A, 6'h19, 6'h18, 6'h11, 6'h11, 6'h14, 6'h14,
    6'h35, 6'h36, 6'h1C, 6'h0A, 6'h01, 6'h10, 6'h00, 6'h00
  };

endpackage

FILE: rtl/core/scrh_exec.sv
// chip register file, request logic and per-item result decode
module scrh_exec (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 card_kind,
  input  scrh_pkg::cmd_t       command,
  input  logic [2:0]           reg_addr,
  input  logic [7:0]           write_data,
  input  logic [7:0]           port_control,
  output scrh_pkg::result_t    res_nxt
);
  import scrh_pkg::*;

  logic [7:0] duration_phoneme_r, duration_phoneme_nxt;
  logic [7:0] inflection_r, inflection_nxt;
  logic [7:0] rate_inflection_r, rate_inflection_nxt;
  logic [7:0] control_amp_r, control_amp_nxt;
  logic [7:0] filter_r, filter_nxt;
  logic [1:0] latched_mode_r, latched_mode_nxt;
  logic       request_flag_r, request_flag_nxt;
  logic       alt_pending_r, alt_pending_nxt;

  always_comb begin
    duration_phoneme_nxt = duration_phoneme_r;
    inflection_nxt       = inflection_r;
    rate_inflection_nxt  = rate_inflection_r;
    control_amp_nxt      = control_amp_r;
    filter_nxt           = filter_r;
    latched_mode_nxt     = latched_mode_r;
    request_flag_nxt     = request_flag_r;
    alt_pending_nxt      = alt_pending_r;
    res_nxt              = '0;

    unique case (command)
      CMD_REG_WR: begin
        unique case (reg_addr)
          ADDR_DURATION: begin
            res_nxt.cpu_irq_clear = card_kind;
            request_flag_nxt      = 1'b0;
            duration_phoneme_nxt  = write_data;
            res_nxt.play_start    = 1'b1;
            res_nxt.phoneme_code  = write_data[5:0];
          end
          ADDR_INFLECTION: inflection_nxt = write_data;
          ADDR_RATE:       rate_inflection_nxt = write_data;
          ADDR_CONTROL: begin
            // falling control bit latches the duration mode
            if (control_amp_r[CtrlBit] && !write_data[CtrlBit]) begin
              latched_mode_nxt = duration_phoneme_r[7:6];
              request_flag_nxt = 1'b0;
            end
            control_amp_nxt = write_data;
          end
          default: filter_nxt = write_data;
        endcase
      end
      CMD_REG_RD: ;
      CMD_ALT_WR: begin
        alt_pending_nxt        = 1'b1;
        res_nxt.flag_alt_clear = 1'b1;
        res_nxt.play_start     = 1'b1;
        res_nxt.phoneme_code   = ALT_MAP[write_data[5:0]];
      end
      CMD_DONE: begin
        if (!alt_pending_r) begin
          request_flag_nxt = 1'b1;
          if (latched_mode_r != 2'd0) begin
            if (!card_kind) begin
              res_nxt.flag_peripheral_set = !port_control[0];
              if (port_control == PCR_HOLD) request_flag_nxt = 1'b0;
            end else begin
              res_nxt.cpu_irq_set = 1'b1;
            end
          end
        end else if (port_control == PCR_ALT_DONE) begin
          res_nxt.flag_alt_set = 1'b1;
          alt_pending_nxt      = 1'b0;
        end
      end
      default: ;
    endcase

    res_nxt.request_pin = request_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_phoneme_r <= '0;
      inflection_r       <= '0;
      rate_inflection_r  <= '0;
      control_amp_r      <= '0;
      filter_r           <= '0;
      latched_mode_r     <= '0;
      request_flag_r     <= 1'b0;
      alt_pending_r      <= 1'b0;
    end else if (in_fire) begin
      duration_phoneme_r <= duration_phoneme_nxt;
      inflection_r       <= inflection_nxt;
      rate_inflection_r  <= rate_inflection_nxt;
      control_amp_r      <= control_amp_nxt;
      filter_r           <= filter_nxt;
      latched_mode_r     <= latched_mode_nxt;
      request_flag_r     <= request_flag_nxt;
      alt_pending_r      <= alt_pending_nxt;
    end
  end

endmodule

FILE: rtl/core/scrh_out_reg.sv
// result register of the speech register block
module scrh_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  scrh_pkg::result_t  res_nxt,
  input  logic               out_ready,
  output logic               out_valid,
  output scrh_pkg::result_t  res
);
  import scrh_pkg::*;

  logic    out_valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/core/speech_chip_register_handshake_core.sv
// top level of the speech chip register and handshake block
// Register and handshake front end of a phoneme speech chip. Each input item
// is a register write, a register read, an alternate phoneme port write or a
// phoneme complete event, and yields exactly one result item: the request pin
// after the item, an optional phoneme start with its 6-bit code, and the
// interrupt and flag strobes. An item is decoded and the chip registers are
// updated in the cycle it is accepted; its result shows on the out_ side in the
// cycle after from a single result register. Throughput is one item per
// cycle: the input is ready whenever the result register is empty or its
// item is being taken in the same cycle, so the result register is the only
// point where the two sides wait on each other.
// card_kind is to be written through cfg_we/cfg_wdata while no item is in flight; not enforced.
module speech_chip_register_handshake_core (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  // input items
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [2:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_port_control,
  // result items
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_request_pin,
  output logic       out_play_start,
  output logic [5:0] out_phoneme_code,
  output logic       out_cpu_irq_set,
  output logic       out_cpu_irq_clear,
  output logic       out_flag_peripheral_set,
  output logic       out_flag_alt_set,
  output logic       out_flag_alt_clear
);
  import scrh_pkg::*;

  logic    card_kind_r;
  logic    in_fire;
  result_t res_nxt;
  result_t res;

  // card type, pin also drives the cpu interrupt when set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_kind_r <= 1'b0;
    end else if (cfg_we) begin
      card_kind_r <= cfg_wdata;
    end
  end

  // accept when the result slot is free or drains this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  scrh_exec u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .card_kind    (card_kind_r),
    .command      (cmd_t'(in_command)),
    .reg_addr     (in_reg_addr),
    .write_data   (in_write_data),
    .port_control (in_port_control),
    .res_nxt      (res_nxt)
  );

  scrh_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res_nxt   (res_nxt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  // result fields out to their own ports
  assign out_request_pin         = res.request_pin;
  assign out_play_start          = res.play_start;
  assign out_phoneme_code        = res.phoneme_code;
  assign out_cpu_irq_set         = res.cpu_irq_set;
  assign out_cpu_irq_clear       = res.cpu_irq_clear;
  assign out_flag_peripheral_set = res.flag_peripheral_set;
  assign out_flag_alt_set        = res.flag_alt_set;
  assign out_flag_alt_clear      = res.flag_alt_clear;

endmodule

FILE: rtl/core/scrh_checker.sv
// port-level checker for the speech register block and its bind
`include "speech_chip_register_handshake_core_assert.svh"

module scrh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_request_pin,
  input logic       out_play_start,
  input logic [5:0] out_phoneme_code,
  input logic       out_cpu_irq_set,
  input logic       out_cpu_irq_clear
);

  // a result waits until taken
  `SCRH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // no phoneme start means a zero code
  `SCRH_ASSERT_NOW(a_code_idle, clk, rst_n, out_valid && !out_play_start, out_phoneme_code == 6'd0)

  // direct interrupt set only comes with the pin raised
  `SCRH_ASSERT_NOW(a_irq_pin, clk, rst_n, out_valid && out_cpu_irq_set, out_request_pin)

  // interrupt clear only on a duration write, which starts a phoneme and drops the pin
  `SCRH_ASSERT_NOW(a_irq_clr_play, clk, rst_n, out_valid && out_cpu_irq_clear, out_play_start && !out_request_pin)

endmodule

bind speech_chip_register_handshake_core scrh_checker u_scrh_checker (.*);

FILE: tb/tb_speech_chip_register_handshake_core.sv
// self-checking testbench for the speech chip register and handshake block
module tb_speech_chip_register_handshake_core;
  timeunit 1ns;
  timeprecision 1ps;

  import scrh_pkg::*;

  localparam int ClkHalf     = 6;
  localparam int ResetCycles = 12;
  localparam int ItemTarget  = 550;
  localparam int PhaseItems  = 110;
  localparam int LongHold    = 80;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 4;
  localparam int ShownLimit  = 40;

  // filter register sits on the four top addresses
  localparam logic [2:0] ADDR_FILTER = 3'd4;
  localparam logic [7:0] CTRL_MASK   = 8'h80;

  // alternate port code to chip phoneme
  localparam logic [5:0] PHONEME_REMAP [64] = '{
    6'h02, 6'h0A, 6'h0B, 6'h00, 6'h28, 6'h08, 6'h08, 6'h2F,
    6'h0E, 6'h07, 6'h07, 6'h07, 6'h37, 6'h38, 6'h24, 6'h33,
    6'h32, 6'h32, 6'h2F, 6'h10, 6'h39, 6'h0F, 6'h13, 6'h13,
    6'h20, 6'h29, 6'h25, 6'h2C, 6'h26, 6'h34, 6'h25, 6'h30,
    6'h08, 6'h09, 6'h03, 6'h1B, 6'h0E, 6'h27, 6'h11, 6'h07,
    6'h16, 6'h05, 6'h28, 6'h1D, 6'h01, 6'h23, 6'h0C, 6'h0D,
    6'h10, 6'h1A, 6'h19, 6'h18, 6'h11, 6'h11, 6'h14, 6'h14,
    6'h35, 6'h36, 6'h1C, 6'h0A, 6'h01, 6'h10, 6'h00, 6'h00
  };

  // chip register shadow, expected result store and mismatch count
  class speech_scoreboard;
    logic       card_kind;
    logic [7:0] duration_reg;
    logic [7:0] inflection_reg;
    logic [7:0] rate_reg;
    logic [7:0] control_reg;
    logic [7:0] filter_reg;
    logic [1:0] duration_mode;
    logic       request_flag;
    logic       alt_pending;
    result_t    expected_results[$];
    int         mismatches;
    int         shown;
    int         results_checked;
    int         items_by_cmd[4];

    function new();
      card_kind       = 1'b0;
      duration_reg    = '0;
      inflection_reg  = '0;
      rate_reg        = '0;
      control_reg     = '0;
      filter_reg      = '0;
      duration_mode   = '0;
      request_flag    = 1'b0;
      alt_pending     = 1'b0;
      mismatches      = 0;
      shown           = 0;
      results_checked = 0;
      items_by_cmd    = '{default: 0};
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    // update the shadow for one accepted item and queue the result it yields
    function void note_item(cmd_t cmd, logic [2:0] addr, logic [7:0] data, logic [7:0] pcr);
      result_t res;
      res = '0;
      items_by_cmd[cmd]++;
      case (cmd)
        CMD_REG_WR: begin
          case (addr)
            ADDR_DURATION: begin
              // duration write drops the pin and starts a phoneme, mode untouched
              res.cpu_irq_clear = card_kind;
              request_flag      = 1'b0;
              duration_reg      = data;
              res.play_start    = 1'b1;
              res.phoneme_code  = data[5:0];
            end
            ADDR_INFLECTION: inflection_reg = data;
            ADDR_RATE:       rate_reg = data;
            ADDR_CONTROL: begin
              // falling control bit latches the duration mode
              if (control_reg[CtrlBit] && !data[CtrlBit]) begin
                duration_mode = duration_reg[7:6];
                request_flag  = 1'b0;
              end
              control_reg = data;
            end
            default: filter_reg = data;
          endcase
        end
        CMD_ALT_WR: begin
          alt_pending        = 1'b1;
          res.flag_alt_clear = 1'b1;
          res.play_start     = 1'b1;
          res.phoneme_code   = PHONEME_REMAP[data[5:0]];
        end
        CMD_DONE: begin
          if (!alt_pending) begin
            request_flag = 1'b1;
            if (duration_mode != 2'd0) begin
              if (!card_kind) begin
                res.flag_peripheral_set = !pcr[0];
                if (pcr == PCR_HOLD) request_flag = 1'b0;
              end else begin
                res.cpu_irq_set = 1'b1;
              end
            end
          end else if (pcr == PCR_ALT_DONE) begin
            res.flag_alt_set = 1'b1;
            alt_pending      = 1'b0;
          end
        end
        default: ;
      endcase
      res.request_pin = request_flag;
      expected_results.push_back(res);
    endfunction

    task report(string msg);
      mismatches++;
      // keep the log short when something is badly broken
      if (shown < ShownLimit) begin
        $display("mismatch: %s", msg);
        shown++;
      end
    endtask

    task compare(string field, logic [5:0] got, logic [5:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_checked, field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result with no item waiting");
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      compare("request_pin", 6'(got.request_pin), 6'(want.request_pin));
      compare("play_start", 6'(got.play_start), 6'(want.play_start));
      compare("phoneme_code", got.phoneme_code, want.phoneme_code);
      compare("cpu_irq_set", 6'(got.cpu_irq_set), 6'(want.cpu_irq_set));
      compare("cpu_irq_clear", 6'(got.cpu_irq_clear), 6'(want.cpu_irq_clear));
      compare("flag_peripheral_set", 6'(got.flag_peripheral_set),
              6'(want.flag_peripheral_set));
      compare("flag_alt_set", 6'(got.flag_alt_set), 6'(want.flag_alt_set));
      compare("flag_alt_clear", 6'(got.flag_alt_clear), 6'(want.flag_alt_clear));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_command;
  logic [2:0] in_reg_addr;
  logic [7:0] in_write_data;
  logic [7:0] in_port_control;
  logic       out_valid;
  logic       out_ready;
  logic       out_request_pin;
  logic       out_play_start;
  logic [5:0] out_phoneme_code;
  logic       out_cpu_irq_set;
  logic       out_cpu_irq_clear;
  logic       out_flag_peripheral_set;
  logic       out_flag_alt_set;
  logic       out_flag_alt_clear;

  speech_scoreboard board = new();

  bit no_idle;       // stretch with no gaps on either side
  bit hold_results;  // asks the receiver for one long stall
  int items_sent;
  int idle_cycles;

  speech_chip_register_handshake_core DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_command              (in_command),
    .in_reg_addr             (in_reg_addr),
    .in_write_data           (in_write_data),
    .in_port_control         (in_port_control),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_request_pin         (out_request_pin),
    .out_play_start          (out_play_start),
    .out_phoneme_code        (out_phoneme_code),
    .out_cpu_irq_set         (out_cpu_irq_set),
    .out_cpu_irq_clear       (out_cpu_irq_clear),
    .out_flag_peripheral_set (out_flag_peripheral_set),
    .out_flag_alt_set        (out_flag_alt_set),
    .out_flag_alt_clear      (out_flag_alt_clear)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // both channels sampled at the edge with pre-edge values; the input item
  // is noted before the result so a same-edge pair still lines up
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        board.note_item(cmd_t'(in_command), in_reg_addr, in_write_data, in_port_control);
      if (out_valid && out_ready)
        board.check_result(result_t'({out_request_pin, out_play_start, out_phoneme_code,
                                      out_cpu_irq_set, out_cpu_irq_clear,
                                      out_flag_peripheral_set, out_flag_alt_set,
                                      out_flag_alt_clear}));
      // watchdog: any item moving on either side resets the count
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no item moved for %0d cycles", IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // result side: random stall per item, one long hold on request
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_results = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // offer one item after a random gap and hold it until taken
  task automatic send_item(cmd_t cmd, logic [2:0] addr, logic [7:0] data, logic [7:0] pcr);
    int gap;
    if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_reg_addr     <= addr;
    in_write_data   <= data;
    in_port_control <= pcr;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop offering and wait until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_card_kind(logic kind);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= kind;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.card_kind = kind;
  endtask

  // port control values that hit the special handshake cases often
  function automatic logic [7:0] pick_port_control();
    case ($urandom_range(0, 5))
      0:       return PCR_ALT_DONE;
      1:       return PCR_HOLD;
      2:       return 8'($urandom) & 8'hFE;
      3:       return 8'($urandom) | 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_noise_item();
    send_item(cmd_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // arm control, load duration, drop control to latch the mode, then play
  task automatic send_utterance();
    int steps;
    steps = $urandom_range(2, 8);
    send_item(CMD_REG_WR, ADDR_CONTROL, 8'($urandom) | CTRL_MASK, pick_port_control());
    send_item(CMD_REG_WR, ADDR_DURATION, 8'($urandom), pick_port_control());
    send_item(CMD_REG_WR, ADDR_CONTROL, 8'($urandom) & ~CTRL_MASK, pick_port_control());
    repeat (steps) begin
      case ($urandom_range(0, 6))
        0: send_item(CMD_REG_WR, ADDR_DURATION, 8'($urandom), pick_port_control());
        1: send_item(CMD_ALT_WR, 3'($urandom), 8'($urandom), pick_port_control());
        2: send_item(CMD_REG_RD, 3'($urandom), 8'($urandom), pick_port_control());
        3: send_item(CMD_REG_WR, 3'($urandom_range(1, 7)), 8'($urandom), pick_port_control());
        default: send_item(CMD_DONE, 3'($urandom), 8'($urandom), pick_port_control());
      endcase
    end
  endtask

  initial begin
    int phase_end;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= CMD_REG_RD;
    in_reg_addr     <= '0;
    in_write_data   <= '0;
    in_port_control <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pin-only card
    write_card_kind(1'b0);
    send_item(CMD_REG_RD, ADDR_DURATION, 8'h00, 8'h00);
    send_item(CMD_REG_WR, ADDR_INFLECTION, 8'hFF, 8'hFF);
    send_item(CMD_REG_WR, ADDR_RATE, 8'h00, 8'h00);
    send_item(CMD_REG_WR, ADDR_FILTER, 8'hFF, 8'h00);
    send_item(CMD_REG_WR, ADDR_FILTER + 3'd3, 8'h00, 8'hFF);
    send_item(CMD_REG_WR, ADDR_DURATION, 8'hFF, 8'h00);
    // rising control bit changes nothing, the fall latches mode 3
    send_item(CMD_REG_WR, ADDR_CONTROL, 8'hFF, 8'h00);
    send_item(CMD_REG_WR, ADDR_CONTROL, 8'h00, 8'h00);
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, 8'h00);
    send_item(CMD_REG_RD, 3'd7, 8'hFF, 8'hFF);
    // hold value sets the peripheral flag but pulls the pin back down
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, PCR_HOLD);
    send_item(CMD_DONE, 3'd7, 8'hFF, 8'hFF);
    // duration write of zero plays a pause
    send_item(CMD_REG_WR, ADDR_DURATION, 8'h00, 8'hFF);
    send_item(CMD_ALT_WR, ADDR_DURATION, 8'hFF, 8'h00);
    send_item(CMD_ALT_WR, 3'd7, 8'hC0, 8'hFF);
    // complete while the alternate port waits: only the done value acts
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, 8'h00);
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, PCR_ALT_DONE);
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, PCR_ALT_DONE);
    // control fall with duration zero latches mode 0
    send_item(CMD_REG_WR, ADDR_CONTROL, CTRL_MASK, 8'h00);
    send_item(CMD_REG_WR, ADDR_CONTROL, ~CTRL_MASK, 8'h00);
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, 8'h00);

    // directed: card that also drives the cpu interrupt
    write_card_kind(1'b1);
    send_item(CMD_REG_WR, ADDR_DURATION, 8'h80, 8'h00);
    send_item(CMD_REG_WR, ADDR_CONTROL, CTRL_MASK, 8'h00);
    send_item(CMD_REG_WR, ADDR_CONTROL, 8'h00, 8'h00);
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, PCR_HOLD);
    send_item(CMD_ALT_WR, ADDR_DURATION, 8'h3F, 8'h00);
    send_item(CMD_DONE, ADDR_DURATION, 8'h00, PCR_ALT_DONE);

    // long receiver hold while items keep coming, so the input backs up
    hold_results = 1'b1;
    repeat (3) send_utterance();

    // random phases, card kind alternating, each opened from an idle block
    for (int phase = 0; items_sent < ItemTarget; phase++) begin
      write_card_kind(phase[0]);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end && items_sent < ItemTarget) begin
        if ($urandom_range(0, 3) == 0)
          send_noise_item();
        else
          send_utterance();
      end
    end

    drain_results();
    $display("covered %0d items: %0d writes, %0d reads, %0d alternate, %0d complete, both cards",
             items_sent, board.items_by_cmd[CMD_REG_WR], board.items_by_cmd[CMD_REG_RD],
             board.items_by_cmd[CMD_ALT_WR], board.items_by_cmd[CMD_DONE]);
    $display("checked %0d results, %0d mismatches", board.results_checked, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
